/* rtl/tbwm_pkg.sv */
// Shared types and constants for the touch baseline window-maximum block.
// No dependencies; imported by touch_baseline_window_max.
package tbwm_pkg;

  localparam int unsigned SAMPLE_W     = 14;
  localparam int unsigned MAX_CH       = 6;
  localparam int unsigned PERIOD_W     = 16;
  localparam int unsigned TDATA_W      = 88;  // 6 x 14 bits, padded to whole bytes
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd6000;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,   // waiting for a sample transfer
    ST_LOAD,   // newest row read back, fold the samples in
    ST_SHIFT,  // history advances: open a fresh newest row
    ST_SCAN,   // one bucket row read per cycle into the running max
    ST_LAST,   // fold in the final row
    ST_OUT     // hand the drops to the output register
  } tbwm_state_e;

endpackage

/* rtl/touch_baseline_window_max.sv */
// Touch baseline: per-channel bucketed sliding-window maximum and drop output.
// Depends on tbwm_pkg (widths, reset period, sequencer state type).
//
// One transfer carries a count sample per channel; one transfer comes back with,
// per channel, the maximum over the bucket history minus the current sample. The
// history lives in a ring memory of BUCKETS rows (all channels side by side), and
// a period counter decides when it advances. After acceptance the newest row is
// merged with the samples and written back, a new bucket is opened by an extra
// write when the history advances, a scan reads one bucket row per cycle through
// a single read port and one bank of lane comparators, and the final row is
// folded in before the result is loaded into the output register. The input is
// not ready while an item is in work; the output register lets the next item
// start while a result waits.
// Rows never written since reset read as zero through per-row valid bits, so
// there is no clearing pass. The user must write bucket_period only while idle;
// the block itself does not enforce it.
module touch_baseline_window_max #(
  parameter int unsigned CHANNELS = 6,   // 1..6
  parameter int unsigned BUCKETS  = 20   // 2..64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration: bucket_period
  input  logic                              cfg_we_i,
  input  logic [tbwm_pkg::PERIOD_W-1:0]     cfg_wdata_i,
  // Sample stream
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // sample_0 [13:0], sample_1 [27:14], sample_2 [41:28], sample_3 [55:42],
  // sample_4 [69:56], sample_5 [83:70], zero [87:84]
  input  logic [tbwm_pkg::TDATA_W-1:0]      s_axis_tdata_i,
  // Drop stream
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // drop_0 [13:0], drop_1 [27:14], drop_2 [41:28], drop_3 [55:42],
  // drop_4 [69:56], drop_5 [83:70], zero [87:84]
  output logic [tbwm_pkg::TDATA_W-1:0]      m_axis_tdata_o
);
  import tbwm_pkg::*;

  localparam int unsigned IDX_W = $clog2(BUCKETS);
  localparam int unsigned ROW_W = CHANNELS * SAMPLE_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUCKETS - 1);

  // Registers
  tbwm_state_e              state_q, state_d;
  logic [PERIOD_W-1:0]      period_q;
  logic [PERIOD_W-1:0]      pcnt_q;
  logic                     adv_q;
  logic [IDX_W-1:0]         head_q;
  logic [IDX_W-1:0]         cnt_q;
  logic [BUCKETS-1:0]       vld_q;
  logic [SAMPLE_W-1:0]      smp_q [CHANNELS];
  logic [SAMPLE_W-1:0]      acc_q [CHANNELS];
  logic [ROW_W-1:0]         mem_q [BUCKETS];
  logic [ROW_W-1:0]         rd_data_q;
  logic                     rdv_q;
  logic                     out_valid_q;
  logic [TDATA_W-1:0]       out_data_q;

  // Sequencer controls
  logic                     in_fire;
  logic                     out_load;
  logic                     mem_we;
  logic                     wr_new;     // write the bare samples rather than the merged row
  logic                     cnt_clr;
  logic                     cnt_inc;
  logic                     acc_clr;
  logic                     acc_en;
  logic [IDX_W-1:0]         rd_addr;
  logic [IDX_W-1:0]         wr_addr;
  logic [IDX_W-1:0]         head_nx;

  // Datapath
  logic [ROW_W-1:0]         row_rd;
  logic [ROW_W-1:0]         row_upd;
  logic [ROW_W-1:0]         row_smp;
  logic [ROW_W-1:0]         wr_data;
  logic [SAMPLE_W-1:0]      acc_nx [CHANNELS];
  logic [TDATA_W-1:0]       drop_bus;
  logic [PERIOD_W:0]        pcnt_inc;
  logic [PERIOD_W-1:0]      pcnt_nx;

  assign in_fire  = s_axis_tvalid_i & s_axis_tready_o;
  assign head_nx  = (head_q == LAST_IDX) ? '0 : head_q + IDX_W'(1);
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready_i);

  // Period counter: increment, wrap to zero past the limit
  assign pcnt_inc = {1'b0, pcnt_q} + {{PERIOD_W{1'b0}}, 1'b1};
  assign pcnt_nx  = (pcnt_inc > {1'b0, period_q}) ? '0 : pcnt_inc[PERIOD_W-1:0];

  // Next state and controls
  always_comb begin
    state_d         = state_q;
    s_axis_tready_o = 1'b0;
    mem_we          = 1'b0;
    wr_new          = 1'b0;
    wr_addr         = head_q;
    cnt_clr         = 1'b0;
    cnt_inc         = 1'b0;
    acc_clr         = 1'b0;
    acc_en          = 1'b0;
    rd_addr         = cnt_q;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        rd_addr         = head_q;
        if (s_axis_tvalid_i) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        mem_we  = 1'b1;
        cnt_clr = 1'b1;
        acc_clr = 1'b1;
        state_d = adv_q ? ST_SHIFT : ST_SCAN;
      end
      ST_SHIFT: begin
        mem_we  = 1'b1;
        wr_new  = 1'b1;
        wr_addr = head_nx;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        acc_en  = (cnt_q != '0);
        // index holds at the last row so reads stay inside the memory
        if (cnt_q == LAST_IDX) begin
          state_d = ST_LAST;
        end else begin
          cnt_inc = 1'b1;
        end
      end
      ST_LAST: begin
        acc_en  = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Per-lane merge, running max and drop
  assign row_rd = rdv_q ? rd_data_q : '0;
  always_comb begin
    drop_bus = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      row_smp[c*SAMPLE_W +: SAMPLE_W] = smp_q[c];
      row_upd[c*SAMPLE_W +: SAMPLE_W] =
        (row_rd[c*SAMPLE_W +: SAMPLE_W] < smp_q[c]) ? smp_q[c]
                                                    : row_rd[c*SAMPLE_W +: SAMPLE_W];
      acc_nx[c] = (row_rd[c*SAMPLE_W +: SAMPLE_W] > acc_q[c])
                  ? row_rd[c*SAMPLE_W +: SAMPLE_W] : acc_q[c];
      drop_bus[c*SAMPLE_W +: SAMPLE_W] = acc_q[c] - smp_q[c];
    end
  end
  assign wr_data = wr_new ? row_smp : row_upd;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    <= PERIOD_RESET;
      pcnt_q      <= '0;
      adv_q       <= 1'b0;
      head_q      <= '0;
      cnt_q       <= '0;
      vld_q       <= '0;
      rdv_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        period_q <= cfg_wdata_i;
      end
      if (in_fire) begin
        pcnt_q <= pcnt_nx;
        adv_q  <= (pcnt_nx == '0);
      end
      if (state_q == ST_SHIFT) begin
        head_q <= head_nx;
      end
      if (cnt_clr) begin
        cnt_q <= '0;
      end else if (cnt_inc) begin
        cnt_q <= cnt_q + IDX_W'(1);
      end
      if (mem_we) begin
        vld_q[wr_addr] <= 1'b1;
      end
      rdv_q <= vld_q[rd_addr];
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < CHANNELS; c++) begin
      if (in_fire) begin
        smp_q[c] <= s_axis_tdata_i[c*SAMPLE_W +: SAMPLE_W];
      end
      if (acc_clr) begin
        acc_q[c] <= '0;
      end else if (acc_en) begin
        acc_q[c] <= acc_nx[c];
      end
    end
    if (out_load) begin
      out_data_q <= drop_bus;
    end
  end

  // Bucket ring memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // Checks
  a_accept_starts_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_LOAD) && !s_axis_tready_o)
    else $error("accepted sample did not start the sequence");

  a_scan_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (cnt_q <= LAST_IDX))
    else $error("scan index past last bucket");

  a_result_presented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> m_axis_tvalid_o && (state_q == ST_IDLE))
    else $error("loaded result not presented");

  a_head_row_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> vld_q[head_q])
    else $error("newest bucket row not marked valid before scan");

endmodule
